// ----- rtl/cppf_pkg.sv -----
// shared types, constants and register indexes of the position play filter
package cppf_pkg;

  localparam int POS_WIDTH_DEF  = 20;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int RATIO_FRAC     = 29;
  localparam int SCALE_FRAC     = 12;
  localparam int NORM_BITS      = 30;

  localparam int DZ_W      = 19;
  localparam int SCALE_W   = 16;
  localparam int STEP_W    = 19;
  localparam int CFG_IDX_W = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd4096;
  localparam logic [59:0]        WS_MIN_RESET = 60'd576461302059761664;
  localparam logic [59:0]        WS_MAX_RESET = 60'd576460202546561311;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WS_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WS_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2     = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_HOME, ST_DELTA, ST_DZ_PASS,
    ST_NORM_INIT, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_INIT, ST_SQRT, ST_SQRT_END,
    ST_CHECK, ST_DIV_INIT, ST_DIV, ST_PART_MUL, ST_PART_APPLY,
    ST_ROT_CLR, ST_ROT_MUL, ST_ROT_ACC, ST_SCALE_MUL, ST_AXIS_END,
    ST_STEP_CHECK, ST_STEP_D, ST_OUT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HOME, OP_DELTA, OP_DZ_PASS,
    OP_NORM_INIT, OP_SQ_MUL, OP_SQ_ACC, OP_SQRT_INIT, OP_SQRT_STEP, OP_SQRT_END,
    OP_DIV_INIT, OP_DIV_STEP, OP_PART_MUL, OP_PART_APPLY,
    OP_ROT_CLR, OP_ROT_MUL, OP_ROT_ACC, OP_SCALE_MUL, OP_AXIS_END,
    OP_SETD_STEP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [1:0] col;
    logic       sel_step;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_home;
    logic dz_zero;
    logic step_en;
    logic nrm_gt_dz;
    logic nrm_gt_step;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/cppf_if.sv -----
// valid/ready channels for tracker transactions and target transactions
interface cppf_in_if import cppf_pkg::*; #(parameter int PW = POS_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic signed [PW-1:0] tracker_x;
  logic signed [PW-1:0] tracker_y;
  logic signed [PW-1:0] tracker_z;
  logic signed [PW-1:0] home_ee_x;
  logic signed [PW-1:0] home_ee_y;
  logic signed [PW-1:0] home_ee_z;

  modport source (output valid, req_type, tracker_x, tracker_y, tracker_z,
                  home_ee_x, home_ee_y, home_ee_z, input ready);
  modport sink (input valid, req_type, tracker_x, tracker_y, tracker_z,
                home_ee_x, home_ee_y, home_ee_z, output ready);
endinterface

interface cppf_out_if import cppf_pkg::*; #(parameter int PW = POS_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] target_x;
  logic signed [PW-1:0] target_y;
  logic signed [PW-1:0] target_z;
  logic                 step_limited;

  modport source (output valid, target_x, target_y, target_z, step_limited,
                  input ready);
  modport sink (input valid, target_x, target_y, target_z, step_limited,
                output ready);
endinterface

// ----- rtl/cppf_ctrl.sv -----
// sequencer that steps the datapath through home capture and sample filtering
module cppf_ctrl import cppf_pkg::*; #(
  parameter int PW = POS_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  localparam int SQRT_STEPS = PW + 3;
  localparam int MAX_STEPS  = (SQRT_STEPS > RATIO_FRAC) ? SQRT_STEPS : RATIO_FRAC;
  localparam int CNT_W      = $clog2(MAX_STEPS);

  ctrl_state_t      state_r, state_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [1:0]       col_r, col_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      col_r   <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state, loop indexes and phase
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE:     if (st.in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: state_nxt = st.is_home ? ST_HOME : ST_DELTA;
      ST_HOME:     state_nxt = ST_IDLE;
      ST_DELTA: begin
        phase_nxt = 1'b0;
        axis_nxt  = '0;
        state_nxt = st.dz_zero ? ST_DZ_PASS : ST_NORM_INIT;
      end
      ST_DZ_PASS:   state_nxt = ST_ROT_CLR;
      ST_NORM_INIT: begin
        axis_nxt  = '0;
        state_nxt = ST_SQ_MUL;
      end
      ST_SQ_MUL:    state_nxt = ST_SQ_ACC;
      ST_SQ_ACC: begin
        if (axis_r == 2'd2) begin
          state_nxt = ST_SQRT_INIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQRT_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = ST_SQRT_END;
      end
      ST_SQRT_END:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        axis_nxt = '0;
        if (!phase_r) state_nxt = st.nrm_gt_dz ? ST_DIV_INIT : ST_ROT_CLR;
        else          state_nxt = st.nrm_gt_step ? ST_DIV_INIT : ST_OUT;
      end
      ST_DIV_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RATIO_FRAC - 1)) begin
          axis_nxt  = '0;
          state_nxt = ST_PART_MUL;
        end
      end
      ST_PART_MUL:  state_nxt = ST_PART_APPLY;
      ST_PART_APPLY: begin
        if (axis_r == 2'd2) begin
          axis_nxt  = '0;
          state_nxt = phase_r ? ST_OUT : ST_ROT_CLR;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_PART_MUL;
        end
      end
      ST_ROT_CLR: begin
        col_nxt   = '0;
        state_nxt = ST_ROT_MUL;
      end
      ST_ROT_MUL:   state_nxt = ST_ROT_ACC;
      ST_ROT_ACC: begin
        if (col_r == 2'd2) begin
          state_nxt = ST_SCALE_MUL;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = ST_ROT_MUL;
        end
      end
      ST_SCALE_MUL: state_nxt = ST_AXIS_END;
      ST_AXIS_END: begin
        if (axis_r == 2'd2) begin
          state_nxt = ST_STEP_CHECK;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_ROT_CLR;
        end
      end
      ST_STEP_CHECK: state_nxt = st.step_en ? ST_STEP_D : ST_OUT;
      ST_STEP_D: begin
        phase_nxt = 1'b1;
        state_nxt = ST_NORM_INIT;
      end
      ST_OUT:       if (st.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath command for the current state
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.axis     = axis_r;
    cmd.col      = col_r;
    cmd.sel_step = phase_r;
    unique case (state_r)
      ST_IDLE:       cmd.op = OP_LOAD;
      ST_HOME:       cmd.op = OP_HOME;
      ST_DELTA:      cmd.op = OP_DELTA;
      ST_DZ_PASS:    cmd.op = OP_DZ_PASS;
      ST_NORM_INIT:  cmd.op = OP_NORM_INIT;
      ST_SQ_MUL:     cmd.op = OP_SQ_MUL;
      ST_SQ_ACC:     cmd.op = OP_SQ_ACC;
      ST_SQRT_INIT:  cmd.op = OP_SQRT_INIT;
      ST_SQRT:       cmd.op = OP_SQRT_STEP;
      ST_SQRT_END:   cmd.op = OP_SQRT_END;
      ST_DIV_INIT:   cmd.op = OP_DIV_INIT;
      ST_DIV:        cmd.op = OP_DIV_STEP;
      ST_PART_MUL:   cmd.op = OP_PART_MUL;
      ST_PART_APPLY: cmd.op = OP_PART_APPLY;
      ST_ROT_CLR:    cmd.op = OP_ROT_CLR;
      ST_ROT_MUL:    cmd.op = OP_ROT_MUL;
      ST_ROT_ACC:    cmd.op = OP_ROT_ACC;
      ST_SCALE_MUL:  cmd.op = OP_SCALE_MUL;
      ST_AXIS_END:   cmd.op = OP_AXIS_END;
      ST_STEP_D:     cmd.op = OP_SETD_STEP;
      ST_OUT:        cmd.op = OP_OUT;
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/cppf_dp.sv -----
// filter datapath: state, configuration, shared multiplier, root and ratio units
module cppf_dp import cppf_pkg::*; #(
  parameter int PW    = POS_WIDTH_DEF,
  parameter int CW    = COEF_WIDTH_DEF,
  parameter int CFG_W = 3 * POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  cppf_in_if.sink              in_item,
  cppf_out_if.source           out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW  = PW + 1;
  localparam int DW  = PW + 2;
  localparam int NW  = DW + 1;
  localparam int SW  = 2 * DW + 2;
  localparam int CF  = CW - 2;
  localparam int MA  = DW + 1;
  localparam int MB  = RATIO_FRAC + 2;
  localparam int PRW = MA + MB;
  localparam int RTW = CW + AW + 2;
  localparam int XW  = PRW + 2;
  localparam int SHW = $clog2(DW + 1);

  localparam logic signed [XW-1:0] AW_HI = {{(XW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [XW-1:0] AW_LO = ~AW_HI;
  localparam logic signed [XW-1:0] PW_HI = {{(XW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [XW-1:0] PW_LO = ~PW_HI;
  localparam logic signed [XW-1:0] RND_COEF  = XW'(1) << (CF - 1);
  localparam logic signed [XW-1:0] RND_SCALE = XW'(1) << (SCALE_FRAC - 1);
  localparam logic [PRW:0]         RND_PART  = (PRW + 1)'(1) << (RATIO_FRAC - 1);
  localparam logic [SW-1:0]        SQ_TOP    = SW'(1) << (SW - 2);

  function automatic logic signed [AW-1:0] sat_aw(input logic signed [XW-1:0] x);
    if (x > AW_HI) return AW_HI[AW-1:0];
    if (x < AW_LO) return AW_LO[AW-1:0];
    return x[AW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] sat_pw(input logic signed [XW-1:0] x);
    if (x > PW_HI) return PW_HI[PW-1:0];
    if (x < PW_LO) return PW_LO[PW-1:0];
    return x[PW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // configuration
  logic [DZ_W-1:0]    dz_r;
  logic [SCALE_W-1:0] scale_r;
  logic [STEP_W-1:0]  step_r;
  logic [3*PW-1:0]    ws_min_r, ws_max_r;
  logic [3*CW-1:0]    row_r [3];

  // filter state
  logic signed [PW-1:0] th_r [3];
  logic signed [PW-1:0] eh_r [3];
  logic signed [PW-1:0] prev_r [3];
  logic signed [AW-1:0] acc_r [3];
  logic                 acc_known_r, prev_known_r, out_valid_r;

  // working registers
  logic                  req_r;
  logic signed [PW-1:0]  trk_r [3];
  logic signed [PW-1:0]  eein_r [3];
  logic signed [AW-1:0]  delta_r [3];
  logic signed [DW-1:0]  d_r [3];
  logic signed [PW-1:0]  p_r [3];
  logic signed [PW-1:0]  outp_r [3];
  logic                  limited_r, out_lim_r;
  logic [SHW-1:0]        s_r;
  logic [SW-1:0]         sum_r, sqv_r, root_r, bit_r;
  logic [NW-1:0]         nrm_r, drem_r;
  logic [RATIO_FRAC-1:0] q_r;
  logic signed [PRW-1:0] prod_r;
  logic signed [RTW-1:0] rot_r;

  // combinational helpers
  logic                  in_take;
  logic [DW-1:0]         mag_c [3];
  logic [DW-1:0]         mx_c;
  logic [SHW-1:0]        shift_c;
  logic [DW-1:0]         t_c;
  logic [SW-1:0]         trial_c;
  logic                  sq_ge_c;
  logic [NW:0]           dtwo_c;
  logic                  div_ge_c;
  logic [NW-1:0]         num_c;
  logic [PRW:0]          pr_sum_c;
  logic [DW-1:0]         qq_c;
  logic signed [DW:0]    sq_c;
  logic signed [AW-1:0]  delta_c [3];
  logic signed [AW-1:0]  rot_sat_c, scale_sat_c;
  logic signed [AW:0]    v_c;
  logic signed [PW-1:0]  lo_c, hi_c, emin_c, emax_c, clamp_c;
  logic signed [CW-1:0]  coef_c;
  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic signed [PRW-1:0] prod_c;

  assign in_take       = in_item.valid && (cmd.op == OP_LOAD);
  assign in_item.ready = (cmd.op == OP_LOAD);

  // displacement from tracker home, and the magnitude of each filter delta
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      delta_c[i] = AW'(trk_r[i]) - AW'(th_r[i]);
      mag_c[i]   = mag_of(d_r[i]);
    end
  end

  // common right shift that keeps every component below 2^30
  always_comb begin
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
    shift_c = '0;
    for (int k = 0; k < DW; k++) begin
      if ((mx_c >> (k + NORM_BITS)) != '0) shift_c = SHW'(k + 1);
    end
  end

  assign t_c = mag_c[cmd.axis] >> s_r;

  // square root and ratio step terms
  assign trial_c  = root_r + bit_r;
  assign sq_ge_c  = (sqv_r >= trial_c);
  assign dtwo_c   = {drem_r, 1'b0};
  assign div_ge_c = (dtwo_c >= {1'b0, nrm_r});
  // ratio numerator: step limit, or the part of the norm beyond the deadzone
  assign num_c    = cmd.sel_step ? NW'(step_r) : nrm_r - NW'(dz_r);

  // signed fraction of one axis, rounded half away from zero
  assign pr_sum_c = {1'b0, prod_r} + RND_PART;
  assign qq_c     = DW'(pr_sum_c >> RATIO_FRAC);
  assign sq_c     = d_r[cmd.axis][DW-1] ? -$signed({1'b0, qq_c}) : $signed({1'b0, qq_c});

  // rotation, gain and workspace clamp of one axis
  assign coef_c      = $signed(row_r[cmd.axis][cmd.col*CW +: CW]);
  assign rot_sat_c   = sat_aw((XW'(rot_r) + RND_COEF) >>> CF);
  assign scale_sat_c = sat_aw((XW'(prod_r) + RND_SCALE) >>> SCALE_FRAC);
  assign v_c         = (AW + 1)'(scale_sat_c) + (AW + 1)'(eh_r[cmd.axis]);
  assign lo_c        = $signed(ws_min_r[cmd.axis*PW +: PW]);
  assign hi_c        = $signed(ws_max_r[cmd.axis*PW +: PW]);
  assign emin_c      = (lo_c < eh_r[cmd.axis]) ? lo_c : eh_r[cmd.axis];
  assign emax_c      = (hi_c > eh_r[cmd.axis]) ? hi_c : eh_r[cmd.axis];

  always_comb begin
    clamp_c = v_c[PW-1:0];
    if (v_c < (AW + 1)'(emin_c)) clamp_c = emin_c;
    if (((v_c < (AW + 1)'(emin_c)) ? (AW + 1)'(emin_c) : v_c) > (AW + 1)'(emax_c)) begin
      clamp_c = emax_c;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ_MUL: begin
        mul_a = $signed(MA'(t_c));
        mul_b = $signed(MB'(t_c));
      end
      OP_PART_MUL: begin
        mul_a = $signed(MA'(mag_c[cmd.axis]));
        mul_b = $signed(MB'(q_r));
      end
      OP_ROT_MUL: begin
        mul_a = MA'(acc_r[cmd.col]);
        mul_b = MB'(coef_c);
      end
      OP_SCALE_MUL: begin
        mul_a = MA'(rot_sat_c);
        mul_b = $signed(MB'(scale_r));
      end
      default: ;
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r         <= '0;
      scale_r      <= SCALE_RESET;
      step_r       <= '0;
      ws_min_r     <= (3 * PW)'(WS_MIN_RESET);
      ws_max_r     <= (3 * PW)'(WS_MAX_RESET);
      for (int i = 0; i < 3; i++) begin
        row_r[i]  <= (3 * CW)'(1) << (i * CW + CF);
        th_r[i]   <= '0;
        eh_r[i]   <= '0;
        prev_r[i] <= '0;
        acc_r[i]  <= '0;
      end
      acc_known_r  <= 1'b0;
      prev_known_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEADZONE: dz_r     <= cfg_data[DZ_W-1:0];
          CFG_SCALE:    scale_r  <= cfg_data[SCALE_W-1:0];
          CFG_MAX_STEP: step_r   <= cfg_data[STEP_W-1:0];
          CFG_WS_MIN:   ws_min_r <= cfg_data[3*PW-1:0];
          CFG_WS_MAX:   ws_max_r <= cfg_data[3*PW-1:0];
          CFG_ROW0:     row_r[0] <= cfg_data[3*CW-1:0];
          CFG_ROW1:     row_r[1] <= cfg_data[3*CW-1:0];
          CFG_ROW2:     row_r[2] <= cfg_data[3*CW-1:0];
          default: ;
        endcase
      end

      // result taken by the receiver and no new one loaded this cycle
      if (out_item.ready && (cmd.op != OP_OUT)) out_valid_r <= 1'b0;

      unique case (cmd.op)
        OP_HOME: begin
          for (int i = 0; i < 3; i++) begin
            th_r[i]   <= trk_r[i];
            eh_r[i]   <= eein_r[i];
            prev_r[i] <= eein_r[i];
            acc_r[i]  <= '0;
          end
          acc_known_r  <= 1'b1;
          prev_known_r <= 1'b1;
        end
        OP_DELTA: begin
          if (!acc_known_r) begin
            for (int i = 0; i < 3; i++) acc_r[i] <= delta_c[i];
          end
          acc_known_r <= 1'b1;
        end
        OP_DZ_PASS: begin
          for (int i = 0; i < 3; i++) acc_r[i] <= delta_r[i];
        end
        OP_PART_APPLY: begin
          if (!cmd.sel_step) begin
            acc_r[cmd.axis] <= sat_aw(XW'(acc_r[cmd.axis]) + XW'(sq_c));
          end
        end
        OP_OUT: begin
          if (!out_valid_r || out_item.ready) begin
            for (int i = 0; i < 3; i++) prev_r[i] <= p_r[i];
            prev_known_r <= 1'b1;
            out_valid_r  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r     <= in_item.req_type;
      trk_r[0]  <= in_item.tracker_x;
      trk_r[1]  <= in_item.tracker_y;
      trk_r[2]  <= in_item.tracker_z;
      eein_r[0] <= in_item.home_ee_x;
      eein_r[1] <= in_item.home_ee_y;
      eein_r[2] <= in_item.home_ee_z;
    end
    unique case (cmd.op)
      OP_DELTA: begin
        for (int i = 0; i < 3; i++) begin
          delta_r[i] <= delta_c[i];
          d_r[i]     <= acc_known_r ? DW'(delta_c[i]) - DW'(acc_r[i]) : '0;
        end
        limited_r <= 1'b0;
      end
      OP_NORM_INIT: begin
        s_r   <= shift_c;
        sum_r <= '0;
      end
      OP_SQ_MUL, OP_PART_MUL, OP_ROT_MUL, OP_SCALE_MUL: prod_r <= prod_c;
      OP_SQ_ACC: sum_r <= sum_r + SW'(prod_r);
      OP_SQRT_INIT: begin
        sqv_r  <= sum_r;
        root_r <= '0;
        bit_r  <= SQ_TOP;
      end
      OP_SQRT_STEP: begin
        if (sq_ge_c) begin
          sqv_r  <= sqv_r - trial_c;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_SQRT_END: nrm_r <= NW'(root_r << s_r);
      OP_DIV_INIT: begin
        drem_r <= num_c;
        q_r    <= '0;
      end
      OP_DIV_STEP: begin
        if (div_ge_c) drem_r <= NW'(dtwo_c - {1'b0, nrm_r});
        else          drem_r <= dtwo_c[NW-1:0];
        q_r <= {q_r[RATIO_FRAC-2:0], div_ge_c};
      end
      OP_PART_APPLY: begin
        if (cmd.sel_step) begin
          p_r[cmd.axis] <= sat_pw(XW'(prev_r[cmd.axis]) + XW'(sq_c));
          limited_r     <= 1'b1;
        end
      end
      OP_ROT_CLR: rot_r <= '0;
      OP_ROT_ACC: rot_r <= rot_r + RTW'(prod_r);
      OP_AXIS_END: p_r[cmd.axis] <= clamp_c;
      OP_SETD_STEP: begin
        for (int i = 0; i < 3; i++) d_r[i] <= DW'(p_r[i]) - DW'(prev_r[i]);
      end
      OP_OUT: begin
        if (!out_valid_r || out_item.ready) begin
          for (int i = 0; i < 3; i++) outp_r[i] <= p_r[i];
          out_lim_r <= limited_r;
        end
      end
      default: ;
    endcase
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.target_x     = outp_r[0];
  assign out_item.target_y     = outp_r[1];
  assign out_item.target_z     = outp_r[2];
  assign out_item.step_limited = out_lim_r;

  // status toward the sequencer
  always_comb begin
    st             = '0;
    st.in_valid    = in_item.valid;
    st.is_home     = req_r;
    st.dz_zero     = (dz_r == '0);
    st.step_en     = prev_known_r && (step_r != '0);
    st.nrm_gt_dz   = (nrm_r > NW'(dz_r));
    st.nrm_gt_step = (nrm_r > NW'(step_r));
    st.out_free    = !out_valid_r || out_item.ready;
  end

endmodule

// ----- rtl/cartesian_position_play_filter_top.sv -----
// top level of the cartesian position play filter
//
//   channel   direction  handshake              payload
//   in_item   in         valid/ready            req_type, tracker_x/y/z, home_ee_x/y/z
//   out_item  out        valid/ready            target_x/y/z, step_limited
//   cfg_*     in         cfg_we, no read-back   cfg_index, cfg_data
//
// a capture-home transaction gives no result. a sample runs longer with the deadband and
// step limit both active than with both off; it is served by the one-bit-per-cycle root
// and ratio units (PW+3 and 29 steps) and the shared multiplier. one transaction is in
// work at a time; the next is taken while a finished result still waits in the output
// register.
// reset is synchronous and active low; no clearing pass is needed.
module cartesian_position_play_filter_top import cppf_pkg::*; #(
  parameter  int POS_WIDTH  = POS_WIDTH_DEF,
  parameter  int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int CFG_W      = (3 * POS_WIDTH > 3 * COEF_WIDTH) ? 3 * POS_WIDTH
                                                                : 3 * COEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cppf_in_if.sink              in_item,
  cppf_out_if.source           out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // sequencer
  cppf_ctrl #(
    .PW (POS_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  // datapath
  cppf_dp #(
    .PW    (POS_WIDTH),
    .CW    (COEF_WIDTH),
    .CFG_W (CFG_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the cartesian position play filter
`timescale 1ns / 100ps
module tb_top;
  import cppf_pkg::*;

  localparam int PW = 20;
  localparam int CW = 16;
  localparam int CFG_W = 60;
  localparam int SETTLE_CYCLES = 400;
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_HOME = 1'b1;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
    logic                 limited;
  } target_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  cppf_in_if #(.PW(PW)) in_item ();
  cppf_out_if #(.PW(PW)) out_item ();

  cartesian_position_play_filter_top u_top (
    .clk(clk), .rst_n(rst_n), .in_item(in_item.sink), .out_item(out_item.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of configuration and filter state
  longint unsigned dz_cfg, scale_cfg, step_cfg, wsmin_cfg, wsmax_cfg;
  longint unsigned row_cfg [3];
  longint trk_home [3], ee_home [3], acc_off [3], prev_tgt [3];
  bit acc_known, prev_known;

  target_t expected_targets [$];
  int error_count = 0;
  int sample_count = 0;
  int target_count = 0;
  int limited_count = 0;
  bit hold_off = 1'b0;
  int max_gap = 6;

  function automatic longint sext(longint unsigned v, int w);
    longint unsigned m;
    m = 64'd1 << (w - 1);
    v = v & ((64'd1 << w) - 1);
    return longint'(v ^ m) - longint'(m);
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint rshift_round(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned length3(longint a, longint b, longint c);
    longint unsigned m [3];
    longint unsigned mx, sum, t;
    int s;
    m[0] = absval(a); m[1] = absval(b); m[2] = absval(c);
    mx = 0; sum = 0; s = 0;
    foreach (m[i]) if (m[i] > mx) mx = m[i];
    while ((mx >> s) >= (64'd1 << 30)) s++;
    foreach (m[i]) begin
      t = m[i] >> s;
      sum += t * t;
    end
    return int_sqrt(sum) << s;
  endfunction

  function automatic longint share_of(longint d, longint unsigned f);
    longint unsigned q;
    q = (absval(d) * f + (64'd1 << (RATIO_FRAC - 1))) >> RATIO_FRAC;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic reset_model();
    dz_cfg = 0; scale_cfg = 4096; step_cfg = 0;
    wsmin_cfg = WS_MIN_RESET; wsmax_cfg = WS_MAX_RESET;
    row_cfg[0] = 64'd16384; row_cfg[1] = 64'd1073741824; row_cfg[2] = 64'd70368744177664;
    for (int i = 0; i < 3; i++) begin
      trk_home[i] = 0; ee_home[i] = 0; acc_off[i] = 0; prev_tgt[i] = 0;
    end
    acc_known = 0; prev_known = 0;
  endtask

  // filter prediction for one accepted transaction
  task automatic predict_filter(logic rt, longint tr [3], longint ee [3]);
    longint delta [3], d [3], p [3];
    longint unsigned nrm, f;
    longint acc, lo, hi, emin, emax;
    target_t t;
    if (rt == REQ_HOME) begin
      for (int i = 0; i < 3; i++) begin
        trk_home[i] = tr[i]; ee_home[i] = ee[i]; acc_off[i] = 0; prev_tgt[i] = ee[i];
      end
      acc_known = 1; prev_known = 1;
      return;
    end
    for (int i = 0; i < 3; i++) delta[i] = tr[i] - trk_home[i];
    if (!acc_known) begin
      for (int i = 0; i < 3; i++) acc_off[i] = delta[i];
      acc_known = 1;
    end
    for (int i = 0; i < 3; i++) d[i] = delta[i] - acc_off[i];
    nrm = length3(d[0], d[1], d[2]);
    if (dz_cfg == 0) begin
      for (int i = 0; i < 3; i++) acc_off[i] = delta[i];
    end else if (nrm > dz_cfg) begin
      f = ((nrm - dz_cfg) << RATIO_FRAC) / nrm;
      for (int i = 0; i < 3; i++) acc_off[i] = clip(acc_off[i] + share_of(d[i], f), PW + 1);
    end
    // rotate, scale, offset and clamp per axis
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += sext(row_cfg[i] >> (j * CW), CW) * acc_off[j];
      acc = clip(rshift_round(acc, CW - 2), PW + 1);
      acc = clip(rshift_round(acc * longint'(scale_cfg), SCALE_FRAC), PW + 1);
      acc += ee_home[i];
      lo = sext(wsmin_cfg >> (i * PW), PW);
      hi = sext(wsmax_cfg >> (i * PW), PW);
      emin = lo < ee_home[i] ? lo : ee_home[i];
      emax = hi > ee_home[i] ? hi : ee_home[i];
      if (acc < emin) acc = emin;
      if (acc > emax) acc = emax;
      p[i] = acc;
    end
    t.limited = 1'b0;
    if (prev_known && step_cfg > 0) begin
      for (int i = 0; i < 3; i++) d[i] = p[i] - prev_tgt[i];
      nrm = length3(d[0], d[1], d[2]);
      if (nrm > step_cfg) begin
        f = (step_cfg << RATIO_FRAC) / nrm;
        for (int i = 0; i < 3; i++) p[i] = clip(prev_tgt[i] + share_of(d[i], f), PW);
        t.limited = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      p[i] = clip(p[i], PW);
      prev_tgt[i] = p[i];
    end
    prev_known = 1;
    t.x = PW'(p[0]); t.y = PW'(p[1]); t.z = PW'(p[2]);
    expected_targets.push_back(t);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // configuration write, only while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEADZONE: dz_cfg = v & ((64'd1 << DZ_W) - 1);
      CFG_SCALE:    scale_cfg = v & ((64'd1 << SCALE_W) - 1);
      CFG_MAX_STEP: step_cfg = v & ((64'd1 << STEP_W) - 1);
      CFG_WS_MIN:   wsmin_cfg = v & ((64'd1 << 60) - 1);
      CFG_WS_MAX:   wsmax_cfg = v & ((64'd1 << 60) - 1);
      CFG_ROW0:     row_cfg[0] = v & ((64'd1 << 48) - 1);
      CFG_ROW1:     row_cfg[1] = v & ((64'd1 << 48) - 1);
      default:      row_cfg[2] = v & ((64'd1 << 48) - 1);
    endcase
  endtask

  // send one transaction; inputs change at the falling edge
  task automatic send_item(logic rt, longint tr [3], longint ee [3]);
    in_item.valid <= 1'b1;
    in_item.req_type <= rt;
    in_item.tracker_x <= PW'(tr[0]);
    in_item.tracker_y <= PW'(tr[1]);
    in_item.tracker_z <= PW'(tr[2]);
    in_item.home_ee_x <= PW'(ee[0]);
    in_item.home_ee_y <= PW'(ee[1]);
    in_item.home_ee_z <= PW'(ee[2]);
    do @(posedge clk); while (!in_item.ready);
    predict_filter(rt, tr, ee);
    if (rt == REQ_SAMPLE) sample_count++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_item.valid <= 1'b0;
    repeat ($urandom_range(1, max_gap)) @(negedge clk);
  endtask

  function automatic longint rand_pos();
    case ($urandom_range(0, 5))
      0: return -524288;
      1: return 524287;
      2: return longint'($urandom_range(0, 4000)) - 2000;
      default: return sext($urandom, PW);
    endcase
  endfunction

  // bursts of samples with random gaps; home capture now and then
  task automatic send_burst_mix(int n, int home_pct, int near);
    longint tr [3], ee [3];
    int burst;
    burst = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        tr[i] = near ? clip(trk_home[i] + longint'($urandom_range(0, 3000)) - 1500, PW)
                     : rand_pos();
        ee[i] = rand_pos();
      end
      send_item(($urandom_range(0, 99) < home_pct) ? REQ_HOME : REQ_SAMPLE, tr, ee);
      if (--burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 12);
      end
    end
    in_item.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_targets.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_one(logic rt, longint x, longint y, longint z,
                          longint ex, longint ey, longint ez);
    longint tr [3], ee [3];
    tr[0] = x; tr[1] = y; tr[2] = z; ee[0] = ex; ee[1] = ey; ee[2] = ez;
    send_item(rt, tr, ee);
    in_item.valid <= 1'b0;
  endtask

  // directed: first sample without home, extremes, home capture, deadband on, step limit on
  task automatic test_directed();
    send_one(REQ_SAMPLE, 1000, -2000, 3000, 0, 0, 0);
    send_one(REQ_SAMPLE, 524287, 524287, 524287, 0, 0, 0);
    send_one(REQ_SAMPLE, -524288, -524288, -524288, 0, 0, 0);
    send_one(REQ_HOME, -524288, 524287, 0, 524287, -524288, 12345);
    send_one(REQ_SAMPLE, 524287, -524288, 524287, 0, 0, 0);
    send_one(REQ_SAMPLE, -524288, 524287, -1, 0, 0, 0);
    wait_drained();
    write_reg(CFG_DEADZONE, 500);
    send_one(REQ_HOME, 0, 0, 0, 100, 200, 300);
    send_one(REQ_SAMPLE, 300, 0, 0, 0, 0, 0);
    send_one(REQ_SAMPLE, 900, 400, 0, 0, 0, 0);
    send_one(REQ_SAMPLE, 524287, 524287, -524288, 0, 0, 0);
    wait_drained();
    write_reg(CFG_DEADZONE, 0);
    write_reg(CFG_MAX_STEP, 1);
    send_one(REQ_SAMPLE, 50000, 0, 0, 0, 0, 0);
    send_one(REQ_SAMPLE, -50000, 7, 9, 0, 0, 0);
    wait_drained();
  endtask

  // random configuration phases, extremes included
  task automatic test_config_phases();
    longint unsigned dz_set [4] = '{0, 1, 2000, 524287};
    longint unsigned step_set [4] = '{0, 1, 3000, 524287};
    longint unsigned scale_set [4] = '{0, 4096, 8192, 65535};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_DEADZONE, dz_set[$urandom_range(0, 3)]);
      write_reg(CFG_SCALE, (ph == 3) ? $urandom : scale_set[ph % 4]);
      write_reg(CFG_MAX_STEP, step_set[$urandom_range(0, 3)]);
      write_reg(CFG_WS_MIN, (ph == 0) ? 64'h0 :
                (ph == 1) ? 64'hFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      write_reg(CFG_WS_MAX, (ph == 0) ? 64'hFFF_FFFF_FFFF_FFFF :
                (ph == 2) ? 64'h0 : {$urandom, $urandom});
      write_reg(CFG_ROW0, (ph < 2) ? 64'hFFFF_FFFF_FFFF : {$urandom, $urandom});
      write_reg(CFG_ROW1, (ph == 2) ? 64'h8000_8000_8000 : {$urandom, $urandom});
      write_reg(CFG_ROW2, (ph == 4) ? 64'h7FFF_7FFF_7FFF : {$urandom, $urandom});
      max_gap = (ph % 2) ? 2 : 20;
      send_burst_mix(40, 8, ph % 2);
      wait_drained();
    end
  endtask

  // identity map with deadband and slew limit, samples near home
  task automatic test_tracking();
    write_reg(CFG_WS_MIN, WS_MIN_RESET);
    write_reg(CFG_WS_MAX, WS_MAX_RESET);
    write_reg(CFG_ROW0, 64'd16384);
    write_reg(CFG_ROW1, 64'd1073741824);
    write_reg(CFG_ROW2, 64'd70368744177664);
    write_reg(CFG_SCALE, 4096);
    write_reg(CFG_DEADZONE, 300);
    write_reg(CFG_MAX_STEP, 400);
    send_burst_mix(200, 3, 1);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      send_burst_mix(80, 5, 0);
    join
    wait_drained();
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_item.ready <= 1'b0;
    else out_item.ready <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    target_t want;
    if (rst_n && out_item.valid && out_item.ready) begin
      if (expected_targets.size() == 0) begin
        report_mismatch("unexpected target", 0, 0);
      end else begin
        want = expected_targets.pop_front();
        target_count++;
        if (out_item.step_limited) limited_count++;
        if (out_item.target_x !== want.x) report_mismatch("target_x", out_item.target_x, want.x);
        if (out_item.target_y !== want.y) report_mismatch("target_y", out_item.target_y, want.y);
        if (out_item.target_z !== want.z) report_mismatch("target_z", out_item.target_z, want.z);
        if (out_item.step_limited !== want.limited)
          report_mismatch("step_limited", out_item.step_limited, want.limited);
      end
    end
  end

  initial begin
    in_item.valid = 1'b0; in_item.req_type = 1'b0;
    in_item.tracker_x = '0; in_item.tracker_y = '0; in_item.tracker_z = '0;
    in_item.home_ee_x = '0; in_item.home_ee_y = '0; in_item.home_ee_z = '0;
    out_item.ready = 1'b0;
    reset_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_phases();
    test_tracking();
    test_backpressure();
    if (expected_targets.size() != 0) report_mismatch("targets left over",
                                                     expected_targets.size(), 0);
    $display("covered %0d samples, %0d targets checked, %0d step-limited",
             sample_count, target_count, limited_count);
    $display("deadband, scale, workspace, rotation and slew limit phases with stalls");
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // overall limit
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
